// ===== hdl/lfps_pkg.sv =====
// ----------------------------------------------------------------------------
// lfps_pkg
// shared types and constants for the line follower pid steering core
// ----------------------------------------------------------------------------
`default_nettype none

package lfps_pkg;

  // configuration register indexes
  localparam logic [0:0] REG_MAX_SPEED = 1'b0;
  localparam logic [0:0] REG_JUNCTION  = 1'b1;

  localparam logic [7:0] MAX_SPEED_RESET = 8'd60;
  localparam logic [9:0] JUNCTION_RESET  = 10'd500;

  // line center
  localparam logic signed [12:0] CENTER_POSITION = 13'sd2000;

  // reciprocal of 10000, exact for any 32-bit unsigned dividend with shift 45
  localparam logic [31:0] RECIP_SUM   = 32'hD1B7_1759;
  localparam int          SUM_SHIFT   = 45;
  // reciprocal of 20, exact for any 12-bit unsigned dividend with shift 16
  localparam logic [11:0] RECIP_PROP  = 12'd3277;
  localparam int          PROP_SHIFT  = 16;

  // first stage: error terms and saturated sum
  typedef struct packed {
    logic signed [12:0] err;
    logic signed [31:0] sum;
    logic signed [13:0] delta;
    logic               junction;
  } s1_t;

  // second stage: scaled terms
  typedef struct packed {
    logic [17:0]        q_mag;     // |sum| / 10000
    logic               sum_neg;
    logic signed [13:0] pd;        // err/20 + (delta*3)/2
    logic               junction;
  } s2_t;

endpackage

`default_nettype wire

// ===== hdl/lfps_front.sv =====
// ----------------------------------------------------------------------------
// lfps_front
// error, saturating error sum and delta; holds the controller state
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sample_valid,
  input  wire logic [11:0]   line_position,
  input  wire logic [9:0]    left_outer_level,
  input  wire logic [9:0]    right_outer_level,
  input  wire logic [9:0]    junction_threshold,
  input  wire logic          dn_ready,
  output logic               take,
  output logic               s1_valid,
  output lfps_pkg::s1_t      s1
);
  import lfps_pkg::*;

  logic signed [12:0] previous_error;
  logic signed [31:0] error_sum;
  logic signed [12:0] err;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic signed [13:0] delta;
  logic               junction;
  logic               accept;

  assign take   = !s1_valid || dn_ready;
  assign accept = sample_valid && take;

  assign err      = $signed({1'b0, line_position}) - CENTER_POSITION;
  assign sum_wide = {error_sum[31], error_sum} + {{20{err[12]}}, err};
  assign delta    = {err[12], err} - {previous_error[12], previous_error};
  assign junction = (left_outer_level > junction_threshold)
                 && (right_outer_level > junction_threshold);

  always_comb begin
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (accept) begin
        previous_error <= junction ? '0 : err;
        error_sum      <= junction ? '0 : sum_sat;
      end
      if (take) begin
        s1_valid <= sample_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.err      <= err;
      s1.sum      <= sum_sat;
      s1.delta    <= delta;
      s1.junction <= junction;
    end
  end

  // a crossing line restarts the controller
  a_junction_clears: assert property (@(posedge clk) disable iff (rst)
    accept && junction |=> previous_error == '0 && error_sum == '0)
    else $error("state not cleared after junction");

endmodule

`default_nettype wire

// ===== hdl/lfps_scale.sv =====
// ----------------------------------------------------------------------------
// lfps_scale
// constant divisions by reciprocal multiply: sum/10000, err/20, delta*3/2
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_scale (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s1_valid,
  input  wire lfps_pkg::s1_t s1,
  input  wire logic          dn_ready,
  output logic               s2_ready,
  output logic               s2_valid,
  output lfps_pkg::s2_t      s2
);
  import lfps_pkg::*;

  logic [31:0]        sum_mag;
  logic [63:0]        sum_prod;
  logic [11:0]        err_mag;
  logic [23:0]        err_prod;
  logic [7:0]         p_mag;
  logic signed [13:0] p_term;
  logic signed [14:0] d3;
  logic signed [14:0] d3_adj;
  logic signed [13:0] d_term;

  assign s2_ready = !s2_valid || dn_ready;

  // magnitudes, so the truncating division works on unsigned values
  assign sum_mag  = s1.sum[31] ? (~s1.sum + 32'd1) : s1.sum;
  assign sum_prod = {32'd0, sum_mag} * {32'd0, RECIP_SUM};

  assign err_mag  = s1.err[12] ? 12'(-s1.err) : s1.err[11:0];
  assign err_prod = {12'd0, err_mag} * {12'd0, RECIP_PROP};
  assign p_mag    = err_prod[PROP_SHIFT +: 8];
  assign p_term   = s1.err[12] ? -$signed({6'd0, p_mag}) : $signed({6'd0, p_mag});

  // delta*3, halved toward zero
  assign d3     = {s1.delta[13], s1.delta} + {s1.delta, 1'b0};
  assign d3_adj = d3 + {14'd0, d3[14]};
  assign d_term = d3_adj[14:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2.q_mag    <= sum_prod[SUM_SHIFT +: 18];
      s2.sum_neg  <= s1.sum[31];
      s2.pd       <= p_term + d_term;
      s2.junction <= s1.junction;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lfps_mix.sv =====
// ----------------------------------------------------------------------------
// lfps_mix
// power sum, clamp to the speed limit and differential wheel speeds
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_mix (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s2_valid,
  input  wire lfps_pkg::s2_t s2,
  input  wire logic [7:0]    max_forward_speed,
  input  wire logic          steer_stall,
  output logic               mix_ready,
  output logic               steer_valid,
  output logic [7:0]         left_wheel_speed,
  output logic [7:0]         right_wheel_speed,
  output logic               junction_found
);
  import lfps_pkg::*;

  logic signed [19:0] q_term;
  logic signed [19:0] power;
  logic signed [19:0] lim_pos;
  logic signed [19:0] lim_neg;
  logic signed [8:0]  pw;
  logic signed [8:0]  lim9;
  logic signed [8:0]  left9;
  logic signed [8:0]  right9;

  assign mix_ready = !steer_valid || !steer_stall;

  assign q_term  = s2.sum_neg ? -$signed({2'd0, s2.q_mag}) : $signed({2'd0, s2.q_mag});
  assign power   = {{6{s2.pd[13]}}, s2.pd} + q_term;
  assign lim_pos = $signed({12'd0, max_forward_speed});
  assign lim_neg = -lim_pos;
  assign lim9    = $signed({1'b0, max_forward_speed});

  always_comb begin
    if (power > lim_pos) begin
      pw = lim_pos[8:0];
    end else if (power < lim_neg) begin
      pw = lim_neg[8:0];
    end else begin
      pw = power[8:0];
    end
    if (pw[8]) begin
      left9  = lim9 + pw;
      right9 = lim9;
    end else begin
      left9  = lim9;
      right9 = lim9 - pw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_valid <= 1'b0;
    end else if (mix_ready) begin
      steer_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_ready && s2_valid) begin
      left_wheel_speed  <= left9[7:0];
      right_wheel_speed <= right9[7:0];
      junction_found    <= s2.junction;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/line_follow_pid_steer_core.sv =====
// ----------------------------------------------------------------------------
// line_follow_pid_steer_core
// pid steering for a line-following differential drive robot
// ----------------------------------------------------------------------------
// throughput: one sample per cycle while the steering channel does not stall,
//   since each of the three register stages (state update, 32x32 reciprocal
//   multiply for the sum term, clamp and mix) reloads in the same cycle that
//   it drains
// reset: synchronous, clears previous error, error sum and all stage valids,
//   loads max_forward_speed = 60 and junction_threshold = 500
`default_nettype none

module line_follow_pid_steer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_write_enable,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  // sample channel
  input  wire logic        sample_valid,
  output logic             sample_stall,
  input  wire logic [11:0] line_position,
  input  wire logic [9:0]  left_outer_level,
  input  wire logic [9:0]  right_outer_level,
  // steering channel
  output logic             steer_valid,
  input  wire logic        steer_stall,
  output logic [7:0]       left_wheel_speed,
  output logic [7:0]       right_wheel_speed,
  output logic             junction_found
);
  import lfps_pkg::*;

  // configuration registers
  logic [7:0] max_forward_speed;
  logic [9:0] junction_threshold;

  // stage handshakes; each stage takes a request when it is empty or drains
  logic  take;
  logic  s1_valid;
  s1_t   s1;
  logic  s2_ready;
  logic  s2_valid;
  s2_t   s2;
  logic  mix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_forward_speed  <= MAX_SPEED_RESET;
      junction_threshold <= JUNCTION_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_MAX_SPEED: max_forward_speed  <= cfg_data[7:0];
        REG_JUNCTION:  junction_threshold <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign sample_stall = !take;

  // stage 1: error, saturating sum, delta, junction compare
  lfps_front u_front (
    .clk                (clk),
    .rst                (rst),
    .sample_valid       (sample_valid),
    .line_position      (line_position),
    .left_outer_level   (left_outer_level),
    .right_outer_level  (right_outer_level),
    .junction_threshold (junction_threshold),
    .dn_ready           (s2_ready),
    .take               (take),
    .s1_valid           (s1_valid),
    .s1                 (s1)
  );

  // stage 2: divisions by constants through reciprocal multiplies
  lfps_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .dn_ready (mix_ready),
    .s2_ready (s2_ready),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  // stage 3: power, clamp and wheel speeds into the result register
  lfps_mix u_mix (
    .clk               (clk),
    .rst               (rst),
    .s2_valid          (s2_valid),
    .s2                (s2),
    .max_forward_speed (max_forward_speed),
    .steer_stall       (steer_stall),
    .mix_ready         (mix_ready),
    .steer_valid       (steer_valid),
    .left_wheel_speed  (left_wheel_speed),
    .right_wheel_speed (right_wheel_speed),
    .junction_found    (junction_found)
  );

  // one wheel always runs at the base speed
  a_one_wheel_full: assert property (@(posedge clk) disable iff (rst)
    steer_valid |-> (left_wheel_speed == max_forward_speed)
                 || (right_wheel_speed == max_forward_speed))
    else $error("neither wheel at base speed");

  // full pipe behind a stalled result blocks new samples
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    steer_valid && steer_stall && s1_valid && s2_valid |-> sample_stall)
    else $error("sample taken into a full pipe");

  // a request held in stage 1 is not dropped
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1))
    else $error("stage 1 request lost while blocked");

endmodule

`default_nettype wire

// ===== verif/line_follow_pid_steer_core_tb.sv =====
// ----------------------------------------------------------------------------
// line_follow_pid_steer_core_tb
// self-checking bench for the pid steering core: a scoreboard class predicts
// the wheel speeds and junction flag of every accepted sensor sample and
// compares them, in order, with the steering requests the core returns,
// while both channels idle and stall at random and the limits are changed
// between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follow_pid_steer_core_tb;
  import lfps_pkg::*;

  // a watchdog ends the run after this many cycles with no request moving
  localparam int QUIET_LIMIT = 1000;
  localparam int PIPE_LATENCY = 3;
  localparam int SEGMENTS = 9;
  localparam int SEGMENT_SAMPLES = 210;

  localparam longint PROP_DIV = 20;
  localparam longint INTEG_DIV = 10000;
  localparam longint SUM_HIGH = 64'sd2147483647;
  localparam longint SUM_LOW = -64'sd2147483648;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic       junction;
  } steer_t;

  // predicts the core from its own copy of the limits and pid state, and
  // holds the steering requests still owed by the core
  class steer_scoreboard;
    logic [7:0]  speed_limit;
    logic [9:0]  junction_level;
    longint      prev_err;
    longint      err_sum;
    steer_t      steer_q[$];
    int unsigned errors;

    function void clear();
      speed_limit = MAX_SPEED_RESET;
      junction_level = JUNCTION_RESET;
      prev_err = 0;
      err_sum = 0;
      errors = 0;
      steer_q.delete();
    endfunction

    function void write_reg(logic [0:0] idx, logic [9:0] val);
      if (idx == REG_MAX_SPEED) begin
        speed_limit = val[7:0];
      end else begin
        junction_level = val;
      end
    endfunction

    function int pending();
      return steer_q.size();
    endfunction

    function void add_sample(logic [11:0] pos, logic [9:0] lvl_l, logic [9:0] lvl_r);
      longint err;
      longint delta;
      longint sum;
      longint power;
      longint lim;
      longint left;
      longint right;
      steer_t want;
      err = longint'(pos) - longint'(CENTER_POSITION);
      delta = err - prev_err;
      sum = err_sum + err;
      if (sum > SUM_HIGH) sum = SUM_HIGH;
      if (sum < SUM_LOW) sum = SUM_LOW;
      err_sum = sum;
      prev_err = err;
      // signed division truncates toward zero
      power = err / PROP_DIV + sum / INTEG_DIV + (delta * 3) / 2;
      lim = longint'(speed_limit);
      if (power > lim) power = lim;
      if (power < -lim) power = -lim;
      if (power < 0) begin
        left = lim + power;
        right = lim;
      end else begin
        left = lim;
        right = lim - power;
      end
      want.left = left[7:0];
      want.right = right[7:0];
      want.junction = (lvl_l > junction_level) && (lvl_r > junction_level);
      // a crossing line restarts the pid state
      if (want.junction) begin
        prev_err = 0;
        err_sum = 0;
      end
      steer_q.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_steer(logic [7:0] left, logic [7:0] right, logic junction);
      steer_t want;
      if (steer_q.size() == 0) begin
        report_mismatch("steer request with no sample outstanding");
      end else begin
        want = steer_q.pop_front();
        if (left !== want.left)
          report_mismatch($sformatf("left speed %0d, want %0d", left, want.left));
        if (right !== want.right)
          report_mismatch($sformatf("right speed %0d, want %0d", right, want.right));
        if (junction !== want.junction)
          report_mismatch($sformatf("junction %b, want %b", junction, want.junction));
      end
    endtask

    task check_leftover();
      if (steer_q.size() != 0)
        report_mismatch($sformatf("%0d steer requests never came", steer_q.size()));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_enable = 1'b0;
  logic [0:0] cfg_index = REG_MAX_SPEED;
  logic [9:0] cfg_data = '0;
  logic       sample_valid = 1'b0;
  logic       sample_stall;
  logic [11:0] line_position = '0;
  logic [9:0] left_outer_level = '0;
  logic [9:0] right_outer_level = '0;
  logic       steer_valid;
  logic       steer_stall = 1'b0;
  logic [7:0] left_wheel_speed;
  logic [7:0] right_wheel_speed;
  logic       junction_found;

  steer_scoreboard sb;
  int idle_pct = 0;     // chance in a hundred that the sender skips a cycle
  int stall_pct = 0;    // chance in a hundred that the receiver stalls
  int track_pos = 2000; // random walk of the line under the sensor bar
  int quiet_cycles = 0;

  line_follow_pid_steer_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .line_position    (line_position),
    .left_outer_level (left_outer_level),
    .right_outer_level(right_outer_level),
    .steer_valid      (steer_valid),
    .steer_stall      (steer_stall),
    .left_wheel_speed (left_wheel_speed),
    .right_wheel_speed(right_wheel_speed),
    .junction_found   (junction_found)
  );

  always #1 clk = ~clk;

  // receiver: random stall on the steering channel
  always @(posedge clk) begin
    if (rst) begin
      steer_stall <= 1'b0;
    end else begin
      steer_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checking and the watchdog; values read here are the ones the
  // core saw at this edge, since its own updates land later in the step
  always @(posedge clk) begin
    if (!rst) begin
      if (steer_valid && !steer_stall)
        sb.check_steer(left_wheel_speed, right_wheel_speed, junction_found);
      if ((sample_valid && !sample_stall) || (steer_valid && !steer_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one sample request; random idle cycles before it, then hold until taken
  task automatic send_sample(input logic [11:0] pos, input logic [9:0] lvl_l,
                             input logic [9:0] lvl_r);
    while ($urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    line_position <= pos;
    left_outer_level <= lvl_l;
    right_outer_level <= lvl_r;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sb.add_sample(pos, lvl_l, lvl_r);
  endtask

  // sender holds off until every steering request is back
  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // register write, only with the core empty
  task automatic write_cfg(input logic [0:0] idx, input logic [9:0] val);
    drain();
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // level at the threshold or one step either side of it
  function automatic int near_level(int thr);
    int v;
    v = thr - 1 + int'($urandom_range(2));
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  // mostly a line drifting near center, with jumps, extremes and junctions
  task automatic next_sample(output logic [11:0] pos, output logic [9:0] lvl_l,
                             output logic [9:0] lvl_r);
    int pick;
    int thr;
    thr = int'(sb.junction_level);
    pick = $urandom_range(99);
    if (pick < 6) begin
      track_pos = $urandom_range(4095);
    end else if (pick < 8) begin
      track_pos = (pick == 6) ? 0 : 4095;
    end else begin
      track_pos = track_pos + int'($urandom_range(160)) - 80;
      if (track_pos < 0) track_pos = 0;
      if (track_pos > 4095) track_pos = 4095;
    end
    pos = track_pos[11:0];
    pick = $urandom_range(99);
    if (pick < 10 && thr < 1023) begin
      // crossing line under both outer sensors
      lvl_l = 10'(thr + 1 + int'($urandom_range(1022 - thr)));
      lvl_r = 10'(thr + 1 + int'($urandom_range(1022 - thr)));
    end else if (pick < 20) begin
      lvl_l = 10'(near_level(thr));
      lvl_r = 10'(near_level(thr));
    end else if (pick < 35) begin
      lvl_l = 10'($urandom_range(1023));
      lvl_r = 10'($urandom_range(1023));
    end else begin
      lvl_l = 10'($urandom_range(thr));
      lvl_r = 10'($urandom_range(1023));
    end
  endtask

  initial begin
    logic [11:0] pos;
    logic [9:0]  lvl_l;
    logic [9:0]  lvl_r;
    int          tail;
    sb = new();
    sb.clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed samples at the reset limits
    idle_pct = 25;
    stall_pct = 68;
    send_sample(12'd2000, 10'd0, 10'd0);       // centered
    send_sample(12'd0, 10'd1000, 10'd0);       // far left, full swing
    send_sample(12'd4000, 10'd0, 10'd1000);    // far right
    send_sample(12'd4095, 10'd1023, 10'd1023); // position past range, junction
    send_sample(12'd4001, 10'd500, 10'd501);   // one level equal to threshold
    send_sample(12'd2019, 10'd501, 10'd501);   // just above threshold
    send_sample(12'd1981, 10'd1023, 10'd0);
    send_sample(12'd2040, 10'd0, 10'd0);
    // zero speed limit clamps power to nothing
    write_cfg(REG_MAX_SPEED, 10'd0);
    send_sample(12'd0, 10'd0, 10'd0);
    send_sample(12'd4095, 10'd0, 10'd0);
    // widest speed limit
    write_cfg(REG_MAX_SPEED, 10'd255);
    send_sample(12'd0, 10'd0, 10'd0);
    send_sample(12'd4095, 10'd0, 10'd0);
    send_sample(12'd2000, 10'd0, 10'd0);
    // thresholds at the top of the sensor range, just below it and at zero
    write_cfg(REG_JUNCTION, 10'd1023);
    send_sample(12'd2000, 10'd1023, 10'd1023);
    write_cfg(REG_JUNCTION, 10'd1001);
    send_sample(12'd2000, 10'd1023, 10'd1002);
    send_sample(12'd2000, 10'd1001, 10'd1023);
    write_cfg(REG_JUNCTION, 10'd0);
    send_sample(12'd2000, 10'd1, 10'd1);
    send_sample(12'd2000, 10'd0, 10'd1);
    // upper data bits are dropped for the speed register
    write_cfg(REG_MAX_SPEED, 10'h2C8);
    send_sample(12'd2500, 10'd0, 10'd0);

    // push the error sum hard one way with no junction possible, then back
    write_cfg(REG_MAX_SPEED, 10'd255);
    write_cfg(REG_JUNCTION, 10'd1023);
    for (tail = 0; tail < 16; tail++) send_sample(12'd4095, 10'd0, 10'd0);
    for (tail = 0; tail < 16; tail++) send_sample(12'd0, 10'd0, 10'd0);

    // random segments: three idling patterns, new limits per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin
          idle_pct = 25;
          stall_pct = 68;
        end
        1: begin
          idle_pct = 68;
          stall_pct = 25;
        end
        default: begin
          idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      write_cfg(REG_MAX_SPEED, (seg == 1) ? 10'd255 : (seg == 4) ? 10'd0 :
                (seg == 6) ? 10'd1 : 10'($urandom_range(255, 20)));
      write_cfg(REG_JUNCTION, (seg == 2) ? 10'd0 : (seg == 5) ? 10'd1023 :
                (seg == 7) ? 10'd1000 : 10'($urandom_range(1023, 200)));
      for (int n = 0; n < SEGMENT_SAMPLES; n++) begin
        next_sample(pos, lvl_l, lvl_r);
        send_sample(pos, lvl_l, lvl_r);
        // mid-segment hold-off until the core is empty
        if (seg == 3 && n == SEGMENT_SAMPLES / 2) drain();
      end
    end

    drain();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
